FILE: sv/btsb_pkg.sv
// btsb_pkg: shared types and constants for the byte taint shadow bitmap
// holds command codes, store sizing, controller states and the control/status structs
// no dependencies

package btsb_pkg;

    // store sizing
    localparam int unsigned TRACKED_WORDS = 2048;
    localparam int unsigned WORD_BITS     = 32;
    localparam int unsigned BIT_IDX_W     = 5;
    localparam int unsigned TRACKED_BITS  = TRACKED_WORDS * WORD_BITS;
    localparam int unsigned WORD_IDX_W    = (TRACKED_WORDS > 1) ? $clog2(TRACKED_WORDS) : 1;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LOW  = 8'd0,
        REG_WINDOW_HIGH = 8'd1
    } cfg_reg_t;

    localparam logic [31:0] WINDOW_LOW_RESET  = 32'h0000_0000;
    localparam logic [31:0] WINDOW_HIGH_RESET = 32'h0000_FFFF;

    // command codes
    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_UNMARK = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // controller states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_MODIFY,
        ST_CLEAR_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep;
        logic read;
        logic load_item;
        logic load_clear;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_free;
        logic in_is_clear;
    } ctrl_status_t;

endpackage

FILE: sv/btsb_ctrl.sv
// btsb_ctrl: controller state machine for the byte taint shadow bitmap
// sequences accept, lookup, read-modify-write and the clearing sweep
// depends on btsb_pkg

module btsb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  btsb_pkg::ctrl_status_t status,
    output btsb_pkg::ctrl_cmd_t   ctrl
);

    btsb_pkg::state_t state_reg;
    btsb_pkg::state_t state_next;
    logic             clear_pending_reg;
    logic             clear_pending_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= btsb_pkg::ST_SWEEP;
            clear_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next         = state_reg;
        clear_pending_next = clear_pending_reg;
        in_ready           = 1'b0;
        ctrl               = '0;
        case (state_reg)
            btsb_pkg::ST_SWEEP:
            begin
                ctrl.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    clear_pending_next = 1'b0;
                    state_next = clear_pending_reg ? btsb_pkg::ST_CLEAR_DONE
                                                   : btsb_pkg::ST_IDLE;
                end
            end
            btsb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    if (status.in_is_clear)
                    begin
                        clear_pending_next = 1'b1;
                        state_next         = btsb_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = btsb_pkg::ST_LOOKUP;
                    end
                end
            end
            btsb_pkg::ST_LOOKUP:
            begin
                ctrl.read  = 1'b1;
                state_next = btsb_pkg::ST_MODIFY;
            end
            btsb_pkg::ST_MODIFY:
            begin
                // write back and hand over the result once the slot is free
                if (status.out_free)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = btsb_pkg::ST_IDLE;
                end
            end
            btsb_pkg::ST_CLEAR_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.load_clear = 1'b1;
                    state_next      = btsb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btsb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/btsb_datapath.sv
// btsb_datapath: window registers, address check, taint word store and result register
// executes the commands of btsb_ctrl and reports status back
// depends on btsb_pkg

module btsb_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  btsb_pkg::ctrl_cmd_t                  ctrl,
    output btsb_pkg::ctrl_status_t               status,
    input  logic                                 cfg_we,
    input  logic [btsb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [btsb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [1:0]                           cmd,
    input  logic [31:0]                          byte_address,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_of_range,
    output logic                                 was_tainted,
    output logic                                 success
);

    localparam int unsigned WIW = btsb_pkg::WORD_IDX_W;

    logic [31:0]  window_low_reg;
    logic [31:0]  window_high_reg;
    logic [WIW-1:0] sweep_cnt_reg;
    logic         out_valid_reg;
    logic         out_of_range_reg;
    logic         was_tainted_reg;
    logic         success_reg;

    logic [1:0]   cmd_reg;
    logic         oor_reg;
    logic [31:0]  offset_reg;
    logic [31:0]  rdata_reg;

    logic [31:0]  taint_mem [btsb_pkg::TRACKED_WORDS];

    logic [31:0]  in_offset;
    logic         in_oor;
    logic [WIW-1:0] word_idx;
    logic [btsb_pkg::BIT_IDX_W-1:0] bit_idx;
    logic [31:0]  bit_mask;
    logic         old_bit;
    logic         change;
    logic         mem_we;
    logic [WIW-1:0] mem_addr;
    logic [31:0]  mem_wdata;

    // address check on the incoming beat
    always_comb
    begin
        in_offset = byte_address - window_low_reg;
        in_oor    = (byte_address < window_low_reg) || (byte_address > window_high_reg)
                 || (in_offset >= 32'(btsb_pkg::TRACKED_BITS));
    end

    // bit selection and change decision
    always_comb
    begin
        word_idx = offset_reg[btsb_pkg::BIT_IDX_W +: WIW];
        bit_idx  = offset_reg[btsb_pkg::BIT_IDX_W-1:0];
        bit_mask = 32'h1 << bit_idx;
        old_bit  = rdata_reg[bit_idx];
        change   = ((cmd_reg == btsb_pkg::CMD_MARK) && !old_bit)
                || ((cmd_reg == btsb_pkg::CMD_UNMARK) && old_bit);
    end

    // store port selection: sweep writes zeros, otherwise write back the flipped word
    always_comb
    begin
        mem_we    = ctrl.sweep || (ctrl.load_item && !oor_reg && change);
        mem_addr  = ctrl.sweep ? sweep_cnt_reg : word_idx;
        mem_wdata = ctrl.sweep ? 32'h0 : (rdata_reg ^ bit_mask);
    end

    // taint word store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            taint_mem[mem_addr] <= mem_wdata;
        end
        if (ctrl.read)
        begin
            rdata_reg <= taint_mem[word_idx];
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg    <= cmd;
            oor_reg    <= in_oor;
            offset_reg <= in_offset;
        end
    end

    // window registers and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= btsb_pkg::WINDOW_LOW_RESET;
            window_high_reg <= btsb_pkg::WINDOW_HIGH_RESET;
            sweep_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == btsb_pkg::REG_WINDOW_LOW))
            begin
                window_low_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == btsb_pkg::REG_WINDOW_HIGH))
            begin
                window_high_reg <= cfg_data;
            end
            if (ctrl.sweep)
            begin
                sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_item || ctrl.load_clear)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            out_of_range_reg <= oor_reg;
            was_tainted_reg  <= !oor_reg && old_bit;
            success_reg      <= !oor_reg && change;
        end
        else if (ctrl.load_clear)
        begin
            out_of_range_reg <= 1'b0;
            was_tainted_reg  <= 1'b0;
            success_reg      <= 1'b1;
        end
    end

    // status and outputs
    always_comb
    begin
        status.sweep_last  = (sweep_cnt_reg == WIW'(btsb_pkg::TRACKED_WORDS - 1));
        status.out_free    = !out_valid_reg || out_ready;
        status.in_is_clear = (cmd == btsb_pkg::CMD_CLEAR);
        out_valid          = out_valid_reg;
        out_of_range       = out_of_range_reg;
        was_tainted        = was_tainted_reg;
        success            = success_reg;
    end

endmodule

FILE: sv/byte_taint_shadow_bitmap.sv
// byte_taint_shadow_bitmap: top level of the byte taint shadow bitmap
// joins btsb_ctrl and btsb_datapath; depends on btsb_pkg

// One taint bit per byte address in the inclusive window set by the window_low
// (index 0) and window_high (index 1) registers, held in 2048 words of 32 bits in
// a single-port store. Query, mark and unmark pass through accept with address
// check, store read and write back, set by the read-modify-write on the one store
// port. The result is registered with the write back, after the store read, and
// the write back waits while an earlier result is still held. One item is in
// flight at a time, and a new item is accepted while the previous result waits
// to be taken. Clear-all and reset both zero the store with a sweep of one word
// per cycle over all 2048 words, during which no item is accepted; the clear-all
// result follows the sweep. Configuration writes are taken at any time and do not
// disturb the store.

module byte_taint_shadow_bitmap (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [btsb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [btsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic [31:0]                      byte_address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_of_range,
    output logic                             was_tainted,
    output logic                             success
);

    btsb_pkg::ctrl_cmd_t    ctrl;
    btsb_pkg::ctrl_status_t status;

    // sequencer
    btsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // store and result path
    btsb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_of_range (out_of_range),
        .was_tainted  (was_tainted),
        .success      (success)
    );

endmodule

FILE: dv/tb_byte_taint_shadow_bitmap.sv
`timescale 1ns / 100ps
// tb_byte_taint_shadow_bitmap: self-checking bench for the byte taint shadow bitmap
// drives command beats and window writes, predicts every result beat and compares it
// depends on btsb_pkg and byte_taint_shadow_bitmap

module tb_byte_taint_shadow_bitmap;

    localparam int unsigned CLK_PERIOD       = 10;
    localparam int unsigned CYCLE_LIMIT      = 1000000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned MAX_REPORTS      = 10;

    typedef struct {
        btsb_pkg::cmd_t op;
        logic [31:0]    addr;
    } taint_cmd_t;

    typedef struct packed {
        logic out_of_range;
        logic was_tainted;
        logic success;
    } taint_resp_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [btsb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [btsb_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [1:0]                       cmd;
    logic [31:0]                      byte_address;
    logic                             out_valid;
    logic                             out_ready;
    logic                             out_of_range;
    logic                             was_tainted;
    logic                             success;

    // shadow copy of the taint store and window
    logic [btsb_pkg::WORD_BITS-1:0] shadow_words [btsb_pkg::TRACKED_WORDS];
    logic [31:0]                    win_low;
    logic [31:0]                    win_high;

    taint_cmd_t  pending_cmds [$];
    taint_resp_t expected_resps [$];

    int unsigned cmds_queued;
    int unsigned cmds_taken;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned holds_asked;
    int unsigned holds_done;
    bit          in_fire;

    // sender and receiver pacing
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    logic [15:0] ready_pattern;
    logic [3:0]  pattern_pos;

    byte_taint_shadow_bitmap DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_of_range (out_of_range),
        .was_tainted  (was_tainted),
        .success      (success)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // applies one command to the shadow store and returns the result it gives
    function automatic taint_resp_t predict_taint(input btsb_pkg::cmd_t op,
                                                  input logic [31:0] addr);
        taint_resp_t                     resp;
        logic [32:0]                     offset;
        logic [btsb_pkg::WORD_IDX_W-1:0] word_sel;
        logic [btsb_pkg::BIT_IDX_W-1:0]  bit_sel;
        logic                            old_bit;
        resp = '0;
        if (op == btsb_pkg::CMD_CLEAR)
        begin
            foreach (shadow_words[i])
                shadow_words[i] = '0;
            resp.success = 1'b1;
            return resp;
        end
        offset = {1'b0, addr} - {1'b0, win_low};
        // below or above the window, or past the end of the store
        if (addr < win_low || addr > win_high || offset >= btsb_pkg::TRACKED_BITS)
        begin
            resp.out_of_range = 1'b1;
            return resp;
        end
        word_sel         = offset[btsb_pkg::BIT_IDX_W +: btsb_pkg::WORD_IDX_W];
        bit_sel          = offset[btsb_pkg::BIT_IDX_W-1:0];
        old_bit          = shadow_words[word_sel][bit_sel];
        resp.was_tainted = old_bit;
        if (op == btsb_pkg::CMD_MARK && !old_bit)
        begin
            shadow_words[word_sel][bit_sel] = 1'b1;
            resp.success = 1'b1;
        end
        else if (op == btsb_pkg::CMD_UNMARK && old_bit)
        begin
            shadow_words[word_sel][bit_sel] = 1'b0;
            resp.success = 1'b1;
        end
        return resp;
    endfunction

    // monitor: result beats first, then the command beat of the same edge
    always @(posedge clk)
    begin : monitor
        taint_resp_t want;
        in_fire = 1'b0;
        cycle_count++;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat at cycle %0d", cycle_count);
                end
                else
                begin
                    want = expected_resps.pop_front();
                    if (out_of_range !== want.out_of_range ||
                        was_tainted !== want.was_tainted ||
                        success !== want.success)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("cycle %0d: expected oor/tainted/ok=%0b%0b%0b, got %0b%0b%0b",
                                     cycle_count, want.out_of_range, want.was_tainted,
                                     want.success, out_of_range, was_tainted, success);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                in_fire = 1'b1;
                expected_resps.push_back(predict_taint(btsb_pkg::cmd_t'(cmd), byte_address));
                cmds_taken++;
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("byte_taint_shadow_bitmap: mismatch");
            $finish;
        end
    end

    // sender: bursts of command beats with random gaps between them
    always @(negedge clk)
    begin : sender
        taint_cmd_t next_cmd;
        if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                cmd          <= next_cmd.op;
                byte_address <= next_cmd.addr;
                in_valid     <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random 16-bit ready patterns, plus a long hold when asked
    always @(negedge clk)
    begin : receiver
        if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_pos == 4'd0)
            begin
                case ($urandom_range(0, 2))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom);
                    default: ready_pattern = 16'($urandom & $urandom);
                endcase
            end
            out_ready   <= ready_pattern[pattern_pos];
            pattern_pos = pattern_pos + 4'd1;
        end
    end

    task automatic push_cmd(input btsb_pkg::cmd_t op, input logic [31:0] addr);
        taint_cmd_t c;
        c.op   = op;
        c.addr = addr;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    // blocks until every queued beat is taken and answered, then lets the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmds_taken != cmds_queued || expected_resps.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input btsb_pkg::cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == btsb_pkg::REG_WINDOW_LOW)
            win_low = value;
        else
            win_high = value;
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
        wait_idle();
        write_reg(btsb_pkg::REG_WINDOW_LOW, lo);
        write_reg(btsb_pkg::REG_WINDOW_HIGH, hi);
    endtask

    function automatic btsb_pkg::cmd_t pick_op();
        int unsigned r;
        r = $urandom_range(0, 63);
        if (r == 0)
            return btsb_pkg::CMD_CLEAR;
        else if (r < 20)
            return btsb_pkg::CMD_QUERY;
        else if (r < 42)
            return btsb_pkg::CMD_MARK;
        return btsb_pkg::CMD_UNMARK;
    endfunction

    // mostly a small working set near the window base so bits get revisited
    function automatic logic [31:0] pick_address(input int unsigned span);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return win_low + $urandom_range(0, span);
        else if (sel < 70)
        begin
            case ($urandom_range(0, 5))
                0:       return win_low - 32'd1;
                1:       return win_low;
                2:       return win_high;
                3:       return win_high + 32'd1;
                4:       return win_low + btsb_pkg::TRACKED_BITS - 1;
                default: return win_low + btsb_pkg::TRACKED_BITS;
            endcase
        end
        else if (sel < 85)
            return win_low + $urandom_range(0, btsb_pkg::TRACKED_BITS - 1);
        return $urandom;
    endfunction

    task automatic run_random(input int unsigned count, input int unsigned span);
        int unsigned n;
        @(posedge clk);
        for (n = 0; n < count; n++)
            push_cmd(pick_op(), pick_address(span));
    endtask

    initial
    begin : stimulus
        logic [31:0] lo;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = btsb_pkg::REG_WINDOW_LOW;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = btsb_pkg::CMD_QUERY;
        byte_address = '0;
        out_ready    = 1'b0;
        in_fire      = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        hold_left    = 0;
        pattern_pos  = '0;
        ready_pattern = '1;
        foreach (shadow_words[i])
            shadow_words[i] = '0;
        win_low  = btsb_pkg::WINDOW_LOW_RESET;
        win_high = btsb_pkg::WINDOW_HIGH_RESET;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: mark and unmark twice, word edges, window top, clear
        @(posedge clk);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd0);
        push_cmd(btsb_pkg::CMD_MARK, 32'd0);
        push_cmd(btsb_pkg::CMD_MARK, 32'd0);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd0);
        push_cmd(btsb_pkg::CMD_UNMARK, 32'd0);
        push_cmd(btsb_pkg::CMD_UNMARK, 32'd0);
        push_cmd(btsb_pkg::CMD_MARK, 32'd31);
        push_cmd(btsb_pkg::CMD_MARK, 32'd32);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd32);
        push_cmd(btsb_pkg::CMD_MARK, 32'd65535);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd65536);
        push_cmd(btsb_pkg::CMD_MARK, 32'hFFFF_FFFF);
        push_cmd(btsb_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd65535);
        push_cmd(btsb_pkg::CMD_UNMARK, 32'd31);
        push_cmd(btsb_pkg::CMD_MARK, 32'd1);

        // shifted window: the bit set above now stands for address 2;
        // the window runs past the store so capacity limits it
        set_window(32'd1, 32'h0002_0000);
        @(posedge clk);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd2);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd0);
        push_cmd(btsb_pkg::CMD_MARK, 32'd65536);
        push_cmd(btsb_pkg::CMD_QUERY, 32'd65537);

        // inverted window: everything out of range, clear still completes
        set_window(32'd100, 32'd50);
        @(posedge clk);
        push_cmd(btsb_pkg::CMD_MARK, 32'd75);
        push_cmd(btsb_pkg::CMD_CLEAR, 32'd0);

        // reset window, long receiver hold, then a full drain mid-phase
        set_window(btsb_pkg::WINDOW_LOW_RESET, btsb_pkg::WINDOW_HIGH_RESET);
        run_random(200, 63);
        holds_asked++;
        wait_idle();
        run_random(200, 63);

        set_window(32'h1000_0000, 32'h1001_8000);
        run_random(350, 511);

        set_window(32'hFFFF_0000, 32'hFFFF_FFFF);
        run_random(300, 511);

        set_window(32'h0000_0000, 32'hFFFF_FFFF);
        run_random(300, 511);

        lo = $urandom;
        set_window(lo, lo + $urandom_range(0, 32'h0003_FFFF));
        run_random(300, 511);

        set_window($urandom, $urandom);
        run_random(100, 511);

        set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(60, 2);

        set_window(32'h0000_0000, 32'h0000_0000);
        run_random(60, 2);

        set_window(32'h8000_0000, 32'h7FFF_FFFF);
        run_random(40, 511);

        wait_idle();
        if (mismatches == 0)
            $display("byte_taint_shadow_bitmap: match");
        else
            $display("byte_taint_shadow_bitmap: mismatch");
        $finish;
    end

endmodule
